// ===== rtl/vfp_pkg.sv =====
// Shared types and constants for the video frame pacer.
// Used by the top level and by the shared divider; depends on nothing.
package vfp_pkg;

    // Field widths
    localparam int STAMP_W   = 48;
    localparam int SAMPLE_W  = 48;
    localparam int FRAMES_W  = 14;
    localparam int RATE_W    = 18;
    localparam int DIV_W     = 58;   // widest dividend: 48-bit samples times 1000
    localparam int SLOT_W    = 7;
    localparam int FILL_W    = 8;
    localparam int COUNT_W   = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;

    // Default ring depth
    localparam int RING_SLOTS_DEF = 128;

    // Clock constants
    localparam int TICK_SAMPLES  = 1600;
    localparam int TICK_RATE     = 48;
    localparam int SKIP_DISTANCE = 2;
    localparam int RATE_RESET    = 48000;

    // Commands
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_AUDIO = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_PUSHED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_SHOWN  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_REPEAT = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_CLOCK  = 3'd5;

    // Configuration register indexes
    localparam logic REG_AUDIO_PRESENT = 1'b0;
    localparam logic REG_SAMPLE_RATE   = 1'b1;

    // Handshake between the sequencer and the divider
    typedef struct packed {
        logic start;
        logic done;
    } div_ctrl_t;

endpackage

// ===== rtl/vfp_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
// Depends on vfp_pkg for the dividend and divisor widths.
module vfp_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [vfp_pkg::DIV_W-1:0]   dividend,
    input  logic [vfp_pkg::RATE_W-1:0]  divisor,
    output logic                        done,
    output logic                        busy,
    output logic [vfp_pkg::DIV_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(vfp_pkg::DIV_W);

    logic                        busy_reg;
    logic                        done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [vfp_pkg::RATE_W-1:0]  rem_reg;
    logic [vfp_pkg::RATE_W-1:0]  dvs_reg;
    logic [vfp_pkg::DIV_W-1:0]   quo_reg;

    logic [vfp_pkg::RATE_W:0]    trial;
    logic [vfp_pkg::RATE_W:0]    diff;
    logic                        fits;
    logic [vfp_pkg::RATE_W-1:0]  rem_next;

    // One restoring step: bring down the next dividend bit and try a subtract.
    always_comb begin
        trial    = {rem_reg, quo_reg[vfp_pkg::DIV_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? diff[vfp_pkg::RATE_W-1:0] : trial[vfp_pkg::RATE_W-1:0];
    end

    // Control: count the steps and pulse done after the last one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(vfp_pkg::DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend register shifts out as the quotient shifts in.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[vfp_pkg::DIV_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/video_frame_pacer_unit.sv =====
// Video frame pacer top level: frame stamp ring, sequencer and output register.
// Depends on vfp_pkg and instantiates the shared divider vfp_div.
//
//  Channel  | Direction | Transfer when          | Contents
//  s_       | in        | s_tvalid & s_tready    | tuser: cmd; tdata: stamp, audio frames
//  m_       | out       | m_tvalid & m_tready    | tuser: status; tdata: result fields
//  cfg_     | in        | cfg_wr_en              | audio_present, sample_rate_hz
//
// A push or a command without work goes from idle straight to the output stage.
// A tick on the free-running clock runs the divider first (divide by 48);
// the ring walk, skipped on an empty ring, makes one ring read per skipped frame.
// An audio item runs the division by the sample rate, unless the rate is zero.
// Reset is synchronous; the ring itself is not cleared, only its pointers.
// The input is not ready while an item is at work or its result waits for the output register.
module video_frame_pacer_unit #(
    parameter int RING_SLOTS = vfp_pkg::RING_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Input channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // frame_stamp_ms[47:0], audio_frames[61:48]
    input  logic [vfp_pkg::CMD_W-1:0]     s_tuser,   // cmd
    // Result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [175:0]                  m_tdata,   // shown_slot[6:0], shown_stamp_ms[54:7],
                                                     // skip_total[86:55], repeat_total[118:87],
                                                     // clock_ms[166:119], fill_level[174:167]
    output logic [vfp_pkg::STATUS_W-1:0]  m_tuser,   // status
    // Configuration
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [vfp_pkg::RATE_W-1:0]    cfg_wr_data
);

    localparam int PTR_W = $clog2(RING_SLOTS);
    localparam int CNT_W = $clog2(RING_SLOTS + 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_DIV_WAIT  = 4'd1;
    localparam logic [3:0] ST_AUD_MUL   = 4'd2;
    localparam logic [3:0] ST_TICK      = 4'd3;
    localparam logic [3:0] ST_CMP_HEAD  = 4'd4;
    localparam logic [3:0] ST_AHEAD     = 4'd5;
    localparam logic [3:0] ST_CMP_AHEAD = 4'd6;
    localparam logic [3:0] ST_RD_SHOW   = 4'd7;
    localparam logic [3:0] ST_SHOW      = 4'd8;
    localparam logic [3:0] ST_DONE      = 4'd9;

    // Registers
    logic [3:0]                       state_reg, state_next;
    logic [PTR_W-1:0]                 head_reg, head_next;
    logic [PTR_W-1:0]                 tail_reg, tail_next;
    logic [CNT_W-1:0]                 fill_reg, fill_next;
    logic [vfp_pkg::COUNT_W-1:0]      skips_reg, skips_next;
    logic [vfp_pkg::COUNT_W-1:0]      repeats_reg, repeats_next;
    logic [vfp_pkg::SAMPLE_W-1:0]     samples_reg, samples_next;
    logic [vfp_pkg::SAMPLE_W-1:0]     clock_reg, clock_next;
    logic [vfp_pkg::STAMP_W-1:0]      last_shown_reg, last_shown_next;
    logic [vfp_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [vfp_pkg::SLOT_W-1:0]       slot_reg, slot_next;
    logic                             div_tick_reg, div_tick_next;
    logic                             audio_present_reg;
    logic [vfp_pkg::RATE_W-1:0]       rate_reg;
    logic                             m_tvalid_reg;
    logic [175:0]                     m_tdata_reg;
    logic [vfp_pkg::STATUS_W-1:0]     m_tuser_reg;

    // Ring memory
    logic [vfp_pkg::STAMP_W-1:0]      ring [RING_SLOTS];
    logic [vfp_pkg::STAMP_W-1:0]      rd_data_reg;
    logic                             ring_we;
    logic                             rd_en;
    logic [PTR_W-1:0]                 rd_addr;

    // Divider hookup
    vfp_pkg::div_ctrl_t               div_ctrl;
    logic                             div_busy;
    logic [vfp_pkg::DIV_W-1:0]        div_dividend;
    logic [vfp_pkg::RATE_W-1:0]       div_divisor;
    logic [vfp_pkg::DIV_W-1:0]        div_quotient;

    // Helpers
    logic                             in_xfer;
    logic                             out_load;
    logic [vfp_pkg::STAMP_W-1:0]      in_stamp;
    logic [vfp_pkg::FRAMES_W-1:0]     in_frames;
    logic [PTR_W:0]                   ahead_sum;
    logic [PTR_W-1:0]                 ahead_ptr;
    logic [PTR_W-1:0]                 head_inc;
    logic [PTR_W-1:0]                 tail_inc;
    logic                             ring_full;
    logic                             more_than_two;
    logic signed [vfp_pkg::STAMP_W:0] clk_s;
    logic signed [vfp_pkg::STAMP_W:0] rd_s;
    logic [vfp_pkg::DIV_W-1:0]        samples_wide;
    logic [vfp_pkg::DIV_W-1:0]        samples_x1000;
    logic [vfp_pkg::SAMPLE_W-1:0]     samples_tick;

    assign in_xfer   = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_stamp  = s_tdata[vfp_pkg::STAMP_W-1:0];
    assign in_frames = s_tdata[vfp_pkg::STAMP_W +: vfp_pkg::FRAMES_W];

    // Pointer arithmetic modulo the ring depth.
    always_comb begin
        head_inc  = (head_reg == PTR_W'(RING_SLOTS - 1)) ? '0 : head_reg + 1'b1;
        tail_inc  = (tail_reg == PTR_W'(RING_SLOTS - 1)) ? '0 : tail_reg + 1'b1;
        ahead_sum = {1'b0, head_reg} + (PTR_W + 1)'(vfp_pkg::SKIP_DISTANCE);
        if (ahead_sum >= (PTR_W + 1)'(RING_SLOTS)) begin
            ahead_sum = ahead_sum - (PTR_W + 1)'(RING_SLOTS);
        end
        ahead_ptr     = ahead_sum[PTR_W-1:0];
        ring_full     = (fill_reg == CNT_W'(RING_SLOTS));
        more_than_two = (fill_reg > CNT_W'(vfp_pkg::SKIP_DISTANCE));
    end

    // The clock is never negative; compare it with the signed stamp one bit wider.
    assign clk_s = $signed({1'b0, clock_reg});
    assign rd_s  = $signed({rd_data_reg[vfp_pkg::STAMP_W-1], rd_data_reg});

    // Samples times 1000 as 1024 - 16 - 8.
    assign samples_wide  = vfp_pkg::DIV_W'(samples_reg);
    assign samples_x1000 = (samples_wide << 10) - (samples_wide << 4) - (samples_wide << 3);
    assign samples_tick  = samples_reg + vfp_pkg::SAMPLE_W'(vfp_pkg::TICK_SAMPLES);

    // Ring reads: the head slot, or the slot two ahead while frames may be skipped.
    assign rd_en   = (state_reg == ST_TICK) || (state_reg == ST_AHEAD) ||
                     (state_reg == ST_RD_SHOW);
    assign rd_addr = ((state_reg == ST_AHEAD) && more_than_two) ? ahead_ptr : head_reg;
    assign ring_we = in_xfer && (s_tuser == vfp_pkg::CMD_PUSH) && !ring_full;

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring[tail_reg] <= in_stamp;
        end
        if (rd_en) begin
            rd_data_reg <= ring[rd_addr];
        end
    end

    // Output register stage is free or emptying this cycle.
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        skips_next      = skips_reg;
        repeats_next    = repeats_reg;
        samples_next    = samples_reg;
        clock_next      = clock_reg;
        last_shown_next = last_shown_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        div_tick_next   = div_tick_reg;
        div_ctrl.start  = 1'b0;
        div_dividend    = samples_x1000;
        div_divisor     = rate_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    slot_next   = '0;
                    status_next = vfp_pkg::STAT_CLOCK;
                    state_next  = ST_DONE;
                    case (s_tuser)
                        vfp_pkg::CMD_PUSH: begin
                            if (ring_full) begin
                                status_next = vfp_pkg::STAT_FULL;
                            end else begin
                                tail_next   = tail_inc;
                                fill_next   = fill_reg + 1'b1;
                                status_next = vfp_pkg::STAT_PUSHED;
                            end
                        end
                        vfp_pkg::CMD_TICK: begin
                            if (!audio_present_reg) begin
                                samples_next   = samples_tick;
                                div_ctrl.start = 1'b1;
                                div_dividend   = vfp_pkg::DIV_W'(samples_tick);
                                div_divisor    = vfp_pkg::RATE_W'(vfp_pkg::TICK_RATE);
                                div_tick_next  = 1'b1;
                                state_next     = ST_DIV_WAIT;
                            end else begin
                                state_next = ST_TICK;
                            end
                        end
                        vfp_pkg::CMD_AUDIO: begin
                            samples_next = samples_reg + vfp_pkg::SAMPLE_W'(in_frames);
                            if (rate_reg != '0) begin
                                div_tick_next = 1'b0;
                                state_next    = ST_AUD_MUL;
                            end
                        end
                        default: begin
                            status_next = vfp_pkg::STAT_CLOCK;
                        end
                    endcase
                end
            end
            ST_AUD_MUL: begin
                div_ctrl.start = 1'b1;
                state_next     = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_ctrl.done) begin
                    clock_next = div_quotient[vfp_pkg::SAMPLE_W-1:0];
                    if (div_tick_reg) begin
                        state_next = ST_TICK;
                    end else begin
                        status_next = vfp_pkg::STAT_CLOCK;
                        state_next  = ST_DONE;
                    end
                end
            end
            ST_TICK: begin
                if (fill_reg == '0) begin
                    status_next = vfp_pkg::STAT_EMPTY;
                    state_next  = ST_DONE;
                end else begin
                    state_next = ST_CMP_HEAD;
                end
            end
            ST_CMP_HEAD: begin
                if (clk_s >= rd_s) begin
                    state_next = ST_AHEAD;
                end else begin
                    repeats_next = repeats_reg + 1'b1;
                    status_next  = vfp_pkg::STAT_REPEAT;
                    state_next   = ST_DONE;
                end
            end
            ST_AHEAD: begin
                state_next = more_than_two ? ST_CMP_AHEAD : ST_SHOW;
            end
            ST_CMP_AHEAD: begin
                // The frame two ahead is already late: drop the head frame.
                if (clk_s > rd_s) begin
                    head_next  = head_inc;
                    fill_next  = fill_reg - 1'b1;
                    skips_next = skips_reg + 1'b1;
                    state_next = ST_AHEAD;
                end else begin
                    state_next = ST_RD_SHOW;
                end
            end
            ST_RD_SHOW: begin
                state_next = ST_SHOW;
            end
            ST_SHOW: begin
                last_shown_next = rd_data_reg;
                slot_next       = vfp_pkg::SLOT_W'(head_reg);
                head_next       = head_inc;
                fill_next       = fill_reg - 1'b1;
                status_next     = vfp_pkg::STAT_SHOWN;
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            tail_reg       <= '0;
            fill_reg       <= '0;
            skips_reg      <= '0;
            repeats_reg    <= '0;
            samples_reg    <= '0;
            clock_reg      <= '0;
            last_shown_reg <= '0;
            div_tick_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            fill_reg       <= fill_next;
            skips_reg      <= skips_next;
            repeats_reg    <= repeats_next;
            samples_reg    <= samples_next;
            clock_reg      <= clock_next;
            last_shown_reg <= last_shown_next;
            div_tick_reg   <= div_tick_next;
        end
    end

    // Per-item result fields
    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            audio_present_reg <= 1'b0;
            rate_reg          <= vfp_pkg::RATE_W'(vfp_pkg::RATE_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                vfp_pkg::REG_AUDIO_PRESENT: audio_present_reg <= cfg_wr_data[0];
                vfp_pkg::REG_SAMPLE_RATE:   rate_reg          <= cfg_wr_data;
                default:                    rate_reg          <= rate_reg;
            endcase
        end
    end

    // Output register: holds a finished result until its transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= status_reg;
            m_tdata_reg <= {1'b0,
                            vfp_pkg::FILL_W'(fill_reg),
                            clock_reg,
                            repeats_reg,
                            skips_reg,
                            last_shown_reg,
                            slot_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Shared divider
    vfp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_ctrl.start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_ctrl.done),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // The ring never holds more frames than it has slots.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(RING_SLOTS))
        else $error("ring fill exceeds its depth");

    // The divider only runs while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_busy |-> (state_reg == ST_DIV_WAIT))
        else $error("divider busy outside its wait state");

    // Comparing against the frame two ahead needs at least three frames.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP_AHEAD) |-> more_than_two)
        else $error("skip check with too few frames");

    // Showing a frame removes exactly one from the ring.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHOW) |=> (fill_reg == $past(fill_reg) - 1'b1))
        else $error("shown frame not removed from ring");

endmodule
